// File: sv/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the script token lexer
// Character codes, scan modes, event and token kinds, the event record
// that travels from the classifier to the serializer, and helpers.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int POS_W   = 21;
    localparam int MAX_EV  = 6;
    localparam int CNT_W   = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [POS_W-1:0] TEXT_MAX_BYTES = 21'd1048576;
    localparam logic [POS_W-1:0] LINE_MAX       = 21'd1048576;

    // character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // scan modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_LINE    = 3'd1;
    localparam logic [2:0] MODE_BLOCK   = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_WORD    = 3'd4;

    // event kinds
    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_CONTENT = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;

    // token kinds
    localparam logic [1:0] KIND_PUNCT  = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_WORD   = 2'd2;

    // position sources
    localparam logic [1:0] POS_SLASH = 2'd0;
    localparam logic [1:0] POS_CUR   = 2'd1;
    localparam logic [1:0] POS_NEXT  = 2'd2;

    typedef struct packed {
        logic [1:0] ev_kind;
        logic [1:0] tok_kind;
        logic       use_slash;
        logic [1:0] pos_sel;
        logic       new_line;
    } ev_t;

    typedef struct packed {
        ev_t  [MAX_EV-1:0] evs;
        logic [CNT_W-1:0]  count;
        logic [7:0]        byte_val;
        logic [POS_W-1:0]  slash_pos;
        logic [POS_W-1:0]  cur_pos;
        logic [POS_W-1:0]  next_pos;
        logic [POS_W-1:0]  old_line;
        logic [POS_W-1:0]  cur_line;
    } entry_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v,
                                                 input logic [POS_W-1:0] max_v);
        logic [POS_W-1:0] r;
        begin
            r = (v >= max_v) ? max_v : v + 1'b1;
            return r;
        end
    endfunction

endpackage

// File: sv/stl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front: byte classifier of the script token lexer
// Holds the scan state, takes one byte a cycle while the queue has room and turns it into a compact
// record of up to six token events for the serializer queue.
// ----------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [2:0]       mode_reg, mode_next;
    logic             slash_reg, slash_next;
    logic             star_reg, star_next;
    logic             bs_reg, bs_next;
    logic [POS_W-1:0] off_reg, off_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W-1:0] start_line_reg, start_line_next;
    logic [1:0]       tok_kind_reg, tok_kind_next;
    logic [POS_W-1:0] slash_at_reg, slash_at_next;

    entry_t           ent;
    logic [CNT_W-1:0] n;
    logic [1:0]       k;
    logic             tnew;
    logic             consumed;
    logic             do_between;
    logic             is_ws;
    logic             is_punct;
    logic [7:0]       b;

    // byte classes
    assign b        = text_byte;
    assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign is_punct = (b == CH_LBRACE) || (b == CH_RBRACE) ||
                      (b == CH_LPAREN) || (b == CH_RPAREN);

    // classify one byte into events and next scan state
    always_comb
    begin
        mode_next       = mode_reg;
        slash_next      = slash_reg;
        star_next       = star_reg;
        bs_next         = bs_reg;
        off_next        = sat_inc(off_reg, TEXT_MAX_BYTES);
        line_next       = line_reg;
        start_line_next = start_line_reg;
        slash_at_next   = slash_at_reg;
        k               = tok_kind_reg;
        tnew            = 1'b0;
        n               = '0;
        consumed        = 1'b0;
        do_between      = 1'b0;

        ent           = '0;
        ent.byte_val  = b;
        ent.slash_pos = slash_at_reg;
        ent.cur_pos   = off_reg;
        ent.next_pos  = sat_inc(off_reg, TEXT_MAX_BYTES);
        ent.old_line  = start_line_reg;
        ent.cur_line  = line_reg;

        if (end_of_text)
        begin
            // flush held slash and open token
            if (slash_reg)
            begin
                if (mode_reg != MODE_WORD)
                begin
                    k = KIND_WORD;
                    tnew = 1'b1;
                    ent.evs[n] = '{EV_START, k, 1'b0, POS_SLASH, tnew};
                    n = n + 1'b1;
                end
                ent.evs[n] = '{EV_CONTENT, KIND_WORD, 1'b1, POS_SLASH, tnew};
                n = n + 1'b1;
                ent.evs[n] = '{EV_END, KIND_WORD, 1'b0, POS_CUR, tnew};
                n = n + 1'b1;
            end
            else if ((mode_reg == MODE_WORD) || (mode_reg == MODE_STRING))
            begin
                ent.evs[n] = '{EV_END, k, 1'b0, POS_CUR, 1'b0};
                n = n + 1'b1;
            end
            mode_next       = MODE_BETWEEN;
            slash_next      = 1'b0;
            star_next       = 1'b0;
            bs_next         = 1'b0;
            off_next        = '0;
            line_next       = POS_W'(1);
            start_line_next = POS_W'(1);
            k               = KIND_PUNCT;
            tnew            = 1'b0;
            slash_at_next   = '0;
        end
        else
        begin
            // resolve a held slash
            if (slash_reg)
            begin
                slash_next = 1'b0;
                if ((b == CH_SLASH) || (b == CH_STAR))
                begin
                    if (mode_next == MODE_WORD)
                    begin
                        ent.evs[n] = '{EV_END, k, 1'b0, POS_SLASH, tnew};
                        n = n + 1'b1;
                    end
                    mode_next = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    star_next = 1'b0;
                    consumed  = 1'b1;
                end
                else
                begin
                    if (mode_next != MODE_WORD)
                    begin
                        k = KIND_WORD;
                        tnew = 1'b1;
                        ent.evs[n] = '{EV_START, k, 1'b0, POS_SLASH, tnew};
                        n = n + 1'b1;
                        mode_next = MODE_WORD;
                    end
                    ent.evs[n] = '{EV_CONTENT, k, 1'b1, POS_SLASH, tnew};
                    n = n + 1'b1;
                end
            end

            // per-mode byte handling
            if (!consumed)
            begin
                unique case (mode_next)
                    MODE_LINE:
                    begin
                        if (b == CH_NL)
                        begin
                            line_next = sat_inc(line_reg, LINE_MAX);
                            mode_next = MODE_BETWEEN;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (star_reg && (b == CH_SLASH))
                        begin
                            mode_next = MODE_BETWEEN;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            if (b == CH_NL)
                            begin
                                line_next = sat_inc(line_reg, LINE_MAX);
                            end
                            star_next = (b == CH_STAR);
                        end
                    end
                    MODE_STRING:
                    begin
                        if ((b == CH_QUOTE) && !bs_reg)
                        begin
                            ent.evs[n] = '{EV_END, k, 1'b0, POS_NEXT, tnew};
                            n = n + 1'b1;
                            mode_next = MODE_BETWEEN;
                            bs_next = 1'b0;
                        end
                        else
                        begin
                            if (b == CH_NL)
                            begin
                                line_next = sat_inc(line_reg, LINE_MAX);
                            end
                            ent.evs[n] = '{EV_CONTENT, k, 1'b0, POS_CUR, tnew};
                            n = n + 1'b1;
                            bs_next = (b == CH_BSLASH);
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_ws || is_punct)
                        begin
                            ent.evs[n] = '{EV_END, k, 1'b0, POS_CUR, tnew};
                            n = n + 1'b1;
                            mode_next = MODE_BETWEEN;
                            do_between = 1'b1;
                        end
                        else if (b == CH_SLASH)
                        begin
                            slash_next = 1'b1;
                            slash_at_next = off_reg;
                        end
                        else
                        begin
                            ent.evs[n] = '{EV_CONTENT, k, 1'b0, POS_CUR, tnew};
                            n = n + 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_BETWEEN;
                        do_between = 1'b1;
                    end
                endcase
            end

            // byte seen between tokens
            if (do_between)
            begin
                if (b == CH_NL)
                begin
                    line_next = sat_inc(line_reg, LINE_MAX);
                end
                else if (is_ws)
                begin
                    mode_next = MODE_BETWEEN;
                end
                else if (b == CH_SLASH)
                begin
                    slash_next = 1'b1;
                    slash_at_next = off_reg;
                end
                else if (is_punct)
                begin
                    k = KIND_PUNCT;
                    tnew = 1'b1;
                    ent.evs[n] = '{EV_START, k, 1'b0, POS_CUR, tnew};
                    n = n + 1'b1;
                    ent.evs[n] = '{EV_CONTENT, k, 1'b0, POS_CUR, tnew};
                    n = n + 1'b1;
                    ent.evs[n] = '{EV_END, k, 1'b0, POS_NEXT, tnew};
                    n = n + 1'b1;
                end
                else if (b == CH_QUOTE)
                begin
                    k = KIND_STRING;
                    tnew = 1'b1;
                    ent.evs[n] = '{EV_START, k, 1'b0, POS_CUR, tnew};
                    n = n + 1'b1;
                    bs_next = 1'b0;
                    mode_next = MODE_STRING;
                end
                else
                begin
                    k = KIND_WORD;
                    tnew = 1'b1;
                    ent.evs[n] = '{EV_START, k, 1'b0, POS_CUR, tnew};
                    n = n + 1'b1;
                    ent.evs[n] = '{EV_CONTENT, k, 1'b0, POS_CUR, tnew};
                    n = n + 1'b1;
                    mode_next = MODE_WORD;
                end
            end

            if (tnew)
            begin
                start_line_next = line_reg;
            end
        end

        ent.count     = n;
        tok_kind_next = k;
    end

    assign q_push  = accept && (n != '0);
    assign q_entry = ent;

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BETWEEN;
            slash_reg      <= 1'b0;
            star_reg       <= 1'b0;
            bs_reg         <= 1'b0;
            off_reg        <= '0;
            line_reg       <= POS_W'(1);
            start_line_reg <= POS_W'(1);
            tok_kind_reg   <= KIND_PUNCT;
            slash_at_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            slash_reg      <= slash_next;
            star_reg       <= star_next;
            bs_reg         <= bs_next;
            off_reg        <= off_next;
            line_reg       <= line_next;
            start_line_reg <= start_line_next;
            tok_kind_reg   <= tok_kind_next;
            slash_at_reg   <= slash_at_next;
        end
    end

endmodule

// File: sv/stl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue: event record queue
// Short register queue between the classifier and the serializer so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module stl_queue
    import stl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   q_full,
    output logic   q_empty
);

    entry_t                entries_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign q_full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign head    = entries_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/stl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back: event serializer
// Walks the events of the oldest queued record one per request and
// retires the record after its last event is taken.
// ----------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  entry_t           head,
    input  logic             q_empty,
    input  logic             pop,
    output logic             q_pop,
    output logic [1:0]       event_kind,
    output logic [1:0]       token_kind,
    output logic [7:0]       content_byte,
    output logic [POS_W-1:0] position,
    output logic [POS_W-1:0] line_no,
    output logic             last_of_run
);

    logic [CNT_W-1:0] idx_reg;
    ev_t              cur;
    logic             take;

    assign cur  = head.evs[idx_reg];
    assign take = pop && !q_empty;

    // event field selection
    always_comb
    begin
        event_kind   = cur.ev_kind;
        token_kind   = cur.tok_kind;
        content_byte = '0;
        if (cur.ev_kind == EV_CONTENT)
        begin
            content_byte = cur.use_slash ? CH_SLASH : head.byte_val;
        end
        case (cur.pos_sel)
            POS_SLASH: position = head.slash_pos;
            POS_CUR:   position = head.cur_pos;
            default:   position = head.next_pos;
        endcase
        line_no     = cur.new_line ? head.cur_line : head.old_line;
        last_of_run = (idx_reg == (head.count - 1'b1));
    end

    assign q_pop = take && last_of_run;

    // event index within the record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= last_of_run ? '0 : idx_reg + 1'b1;
        end
    end

endmodule

// File: sv/script_token_lexer.sv
`timescale 1ns / 1ps
// A byte's record is registered into the record queue when the byte is taken.
// One byte per cycle in while the queue has room, one event per cycle out while pop is held; a byte
// causes up to six events, so the serializer sets the sustained rate.
// The four-entry record queue lets the classifier run ahead of the output.
// Reset: asynchronous, returns to between-tokens, offset 0, line 1.
// ----------------------------------------------------------------------------
// script_token_lexer: script text lexer with comment skipping
// Classifier, record queue and event serializer.
// ----------------------------------------------------------------------------
module script_token_lexer
    import stl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       event_kind,
    output logic [1:0]       token_kind,
    output logic [7:0]       content_byte,
    output logic [POS_W-1:0] position,
    output logic [POS_W-1:0] line_no,
    output logic             last_of_run
);

    entry_t q_entry;
    entry_t head;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    logic   accept;

    // input request taken when the queue has room
    assign full   = q_full;
    assign empty  = q_empty;
    assign accept = push && !q_full;

    stl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    stl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (head),
        .q_full     (q_full),
        .q_empty    (q_empty)
    );

    stl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .q_pop        (q_pop),
        .event_kind   (event_kind),
        .token_kind   (token_kind),
        .content_byte (content_byte),
        .position     (position),
        .line_no      (line_no),
        .last_of_run  (last_of_run)
    );

endmodule
